// ===== sv/sitrd_pkg.sv =====
package sitrd_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int RADIX_W     = 5;
   localparam int CHAR_W      = 7;
   localparam int DIGIT_W     = 4;

   // Quotient bits resolved per cycle by the shared divide unit
   localparam int DIV_LANES   = 8;
   localparam int DIV_STEPS   = (VALUE_BITS + DIV_LANES - 1) / DIV_LANES;
   localparam int DIV_W       = DIV_STEPS * DIV_LANES;
   localparam int STEP_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // Base 2 of the most negative value gives VALUE_BITS digits
   localparam int STACK_DEPTH = VALUE_BITS;
   localparam int IDX_W       = $clog2(STACK_DEPTH);

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [VALUE_BITS-1:0]        mag_type;
   typedef logic [DIV_W-1:0]             div_word_type;
   typedef logic [RADIX_W-1:0]           radix_type;
   typedef logic [CHAR_W-1:0]            char_type;
   typedef logic [DIGIT_W-1:0]           digit_type;
   typedef logic [IDX_W-1:0]             idx_type;
   typedef logic [STEP_W-1:0]            step_type;

   localparam radix_type RADIX_RESET   = RADIX_W'(10);
   localparam radix_type RADIX_MIN     = RADIX_W'(2);
   localparam radix_type RADIX_MAX     = RADIX_W'(16);
   localparam radix_type RADIX_DECIMAL = RADIX_W'(10);
   localparam char_type  MINUS_SIGN    = CHAR_W'(8'h2D);

   localparam char_type DIGIT_CHARS [16] = '{
      CHAR_W'(8'h30), CHAR_W'(8'h31), CHAR_W'(8'h32), CHAR_W'(8'h33),
      CHAR_W'(8'h34), CHAR_W'(8'h35), CHAR_W'(8'h36), CHAR_W'(8'h37),
      CHAR_W'(8'h38), CHAR_W'(8'h39), CHAR_W'(8'h41), CHAR_W'(8'h42),
      CHAR_W'(8'h43), CHAR_W'(8'h44), CHAR_W'(8'h45), CHAR_W'(8'h46)
   };

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
      logic zero;
   } div_status_type;

   function automatic radix_type radix_clamp(input radix_type raw);
      radix_type r;
      r = raw;
      if (raw < RADIX_MIN) begin
         r = RADIX_MIN;
      end else if (raw > RADIX_MAX) begin
         r = RADIX_MAX;
      end
      return r;
   endfunction

   function automatic char_type digit_char(input digit_type d);
      return DIGIT_CHARS[d];
   endfunction

endpackage

// ===== sv/sitrd_req_if.sv =====
interface sitrd_req_if
   import sitrd_pkg::*;
();
   logic      valid;
   logic      ready;
   value_type value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/sitrd_rsp_if.sv =====
interface sitrd_rsp_if
   import sitrd_pkg::*;
();
   logic     valid;
   logic     ready;
   char_type character;
   logic     last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== sv/sitrd_divider.sv =====
module sitrd_divider
   import sitrd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  div_ctrl_type   ctrl,
   input  mag_type        dividend,
   input  radix_type      radix,
   output div_status_type status,
   output mag_type        quotient,
   output digit_type      remainder
);

   logic         busy_ff;
   logic         done_ff;
   step_type     step_ff;
   div_word_type acc_ff;
   div_word_type acc_in;
   digit_type    rem_ff;
   digit_type    rem_in;

   // Restoring division, DIV_LANES quotient bits per cycle; quotient shifts
   // into the low end of the dividend word
   always_comb begin
      div_word_type     acc_v;
      digit_type        rem_v;
      logic [RADIX_W:0] trial;
      acc_v = acc_ff;
      rem_v = rem_ff;
      trial = '0;
      for (int i = 0; i < DIV_LANES; i++) begin
         trial = {1'b0, rem_v, acc_v[DIV_W-1]};
         acc_v = {acc_v[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, radix}) begin
            trial    = trial - {1'b0, radix};
            acc_v[0] = 1'b1;
         end
         rem_v = trial[DIGIT_W-1:0];
      end
      acc_in = acc_v;
      rem_in = rem_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            acc_ff  <= DIV_W'(dividend);
            rem_ff  <= '0;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            acc_ff  <= acc_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.done = done_ff;
   assign status.zero = (acc_ff == '0);
   assign quotient    = acc_ff[VALUE_BITS-1:0];
   assign remainder   = rem_ff;

endmodule

// ===== sv/sitrd_digit_stack.sv =====
module sitrd_digit_stack
   import sitrd_pkg::*;
(
   input  logic      clock,
   input  logic      wr_en,
   input  idx_type   wr_addr,
   input  digit_type wr_data,
   input  idx_type   rd_addr,
   output digit_type rd_data
);

   digit_type mem [STACK_DEPTH];
   digit_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/signed_integer_to_radix_digits.sv =====
// Signed integer to ASCII digits in a programmable base (2..16, letters A-F
// upper case). One transaction on req carries a two's complement value; the
// block answers with one rsp transaction per character, most significant
// digit first, with last set on the final one. A minus sign leads only for a
// negative value in base 10; other bases print the magnitude, so the most
// negative value becomes 2^(VALUE_BITS-1). csr_write_data sets the base; 0
// and 1 act as 2, 17..31 act as 16, and the base resets to 10. Write it only
// while the block is idle. The block handles one value at a time: req_ready
// is high only while idle. A single shared divide unit produces the digits
// one after another, each division starting once the previous one is done;
// characters then leave from a digit stack, after the minus sign if any,
// each passing through the fetch, load and hold states in that order.
module signed_integer_to_radix_digits
   import sitrd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   sitrd_req_if.sink          req,
   sitrd_rsp_if.source        rsp,
   input  logic               csr_write_enable,
   input  radix_type          csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_FETCH,
      ST_LOAD,
      ST_HOLD
   } state_type;

   state_type      state_ff;
   radix_type      radix_ff;
   logic           neg10_ff;
   idx_type        idx_ff;
   logic           rsp_valid_ff;
   char_type       rsp_char_ff;
   logic           rsp_last_ff;

   div_ctrl_type   div_ctrl;
   div_status_type div_status;
   mag_type        div_dividend;
   mag_type        div_quotient;
   digit_type      div_remainder;
   digit_type      stack_rd_data;
   logic           stack_wr_en;

   logic           req_negative;
   mag_type        req_magnitude;
   logic           accept;

   assign accept        = req.valid && (state_ff == ST_IDLE);
   assign req_negative  = req.value[VALUE_BITS-1];
   // Negating the most negative value wraps to 2^(VALUE_BITS-1) unsigned
   assign req_magnitude = req_negative ? mag_type'(-req.value) : mag_type'(req.value);

   // Start a division on acceptance, and again on every nonzero quotient
   always_comb begin
      div_ctrl.start = 1'b0;
      div_dividend   = div_quotient;
      if (accept) begin
         div_ctrl.start = 1'b1;
         div_dividend   = req_magnitude;
      end else if (state_ff == ST_DIVIDE && div_status.done && !div_status.zero) begin
         div_ctrl.start = 1'b1;
      end
   end

   // Push each remainder; digits land least significant first
   assign stack_wr_en = (state_ff == ST_DIVIDE) && div_status.done;

   sitrd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (div_dividend),
      .radix     (radix_ff),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   sitrd_digit_stack u_stack (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (idx_ff),
      .wr_data (div_remainder),
      .rd_addr (idx_ff),
      .rd_data (stack_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         neg10_ff     <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Store the base already clamped to its legal range
         if (csr_write_enable) begin
            radix_ff <= radix_clamp(csr_write_data);
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  neg10_ff <= req_negative && (radix_ff == RADIX_DECIMAL);
                  idx_ff   <= '0;
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_status.done) begin
                  if (div_status.zero) begin
                     // Hold idx on the most significant digit
                     if (neg10_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_char_ff  <= MINUS_SIGN;
                        rsp_last_ff  <= 1'b0;
                        state_ff     <= ST_SIGN;
                     end else begin
                        state_ff <= ST_FETCH;
                     end
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            ST_SIGN: begin
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               // Stack read of idx lands during ST_LOAD
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               rsp_valid_ff <= 1'b1;
               rsp_char_ff  <= digit_char(stack_rd_data);
               rsp_last_ff  <= (idx_ff == '0);
               state_ff     <= ST_HOLD;
            end
            ST_HOLD: begin
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff   <= idx_ff - 1'b1;
                     state_ff <= ST_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.character = rsp_char_ff;
   assign rsp.last      = rsp_last_ff;

endmodule

// ===== sv/sitrd_checker.sv =====
module sitrd_checker
   import sitrd_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input char_type rsp_character,
   input logic     rsp_last
);

   // A stalled transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // One value at a time: no new input while characters are pending
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready high while a character is pending");

   // An accepted value closes the input until its string is done
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after acceptance");

   // Finishing a string reopens the input
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("block not idle after final character");

   // A minus sign is never the whole string
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_character == MINUS_SIGN) |-> !rsp_last)
      else $error("minus sign flagged as last");

endmodule

bind signed_integer_to_radix_digits sitrd_checker u_sitrd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_character (rsp.character),
   .rsp_last      (rsp.last)
);
